[design/named_semaphore_table_assert.svh]
// Assertion macros shared by the named semaphore table RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef NAMED_SEMAPHORE_TABLE_ASSERT_SVH
`define NAMED_SEMAPHORE_TABLE_ASSERT_SVH

`define NST_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

`define NST_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define NST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/nst_pkg.sv]
// Package for the named semaphore table: sizes, codes, probe and write types.
// No dependencies; used by nst_cell and named_semaphore_table.
package nst_pkg;

  localparam int NSEM      = 32;
  localparam int COUNT_W   = 16;
  localparam int IDX_W     = $clog2(NSEM);
  localparam int LINK_W    = $clog2(NSEM + 1);
  localparam int HANDLE_W  = 6;
  localparam int NAME_W    = 32;
  localparam int INIT_W    = 16;
  localparam int OPCODE_W  = 2;
  localparam int STATUS_W  = 2;

  typedef logic signed [COUNT_W-1:0] count_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [LINK_W-1:0]         link_t;

  localparam count_t CNT_MAX   = {1'b0, {(COUNT_W-1){1'b1}}};
  localparam count_t CNT_MIN   = {1'b1, {(COUNT_W-1){1'b0}}};
  localparam link_t  LINK_NONE = LINK_W'(NSEM);

  typedef enum logic [OPCODE_W-1:0] {
    OP_GET    = 2'd0,
    OP_SIGNAL = 2'd1,
    OP_WAIT   = 2'd2,
    OP_DELETE = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_BAD_HANDLE = 2'd2,
    ST_BLOCK      = 2'd3
  } status_e;

  typedef struct packed {
    logic              active;
    logic              is_get;
    logic [NAME_W-1:0] name;
    idx_t              tgt;
    logic              hit;
    idx_t              hit_idx;
    count_t            cnt;
    link_t             link;
  } probe_t;

  typedef struct packed {
    logic              en;
    idx_t              idx;
    logic              wr_valid;
    logic              valid_val;
    logic              wr_key;
    logic [NAME_W-1:0] key;
    logic              wr_count;
    count_t            count;
    logic              wr_link;
    link_t             link;
  } wr_t;

  function automatic count_t clamp_init(logic signed [INIT_W-1:0] v);
    logic signed [31:0] wide;
    wide = 32'(v);
    if (wide > 32'(CNT_MAX)) begin
      return CNT_MAX;
    end else if (wide < 32'(CNT_MIN)) begin
      return CNT_MIN;
    end
    return COUNT_W'(wide);
  endfunction

endpackage

[design/nst_cell.sv]
// One table entry of the semaphore chain: valid, key, count and free link.
// Registers the passing probe each cycle. Depends on nst_pkg.
module nst_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  nst_pkg::idx_t  cell_idx_i,
  input  nst_pkg::probe_t probe_i,
  output nst_pkg::probe_t probe_o,
  input  nst_pkg::wr_t   wr_i
);
  import nst_pkg::*;

  logic              valid_q;
  logic              link_set_q;
  logic [NAME_W-1:0] key_q;
  count_t            count_q;
  link_t             link_q;
  link_t             link_rd;
  probe_t            probe_d;
  probe_t            probe_q;
  logic              wr_hit;

  assign link_rd = link_set_q ? link_q : LINK_W'(cell_idx_i) + LINK_W'(1);
  assign wr_hit  = wr_i.en && (wr_i.idx == cell_idx_i);

  always_comb begin
    probe_d = probe_i;
    if (probe_i.active) begin
      if (probe_i.is_get) begin
        if (valid_q && (key_q == probe_i.name) && !probe_i.hit) begin
          probe_d.hit     = 1'b1;
          probe_d.hit_idx = cell_idx_i;
          probe_d.cnt     = count_q;
        end
        if (probe_i.tgt == cell_idx_i) begin
          probe_d.link = link_rd;
        end
      end else if (probe_i.tgt == cell_idx_i) begin
        probe_d.hit = valid_q;
        probe_d.cnt = count_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q    <= '0;
      valid_q    <= 1'b0;
      link_set_q <= 1'b0;
    end else begin
      probe_q <= probe_d;
      if (wr_hit && wr_i.wr_valid) begin
        valid_q <= wr_i.valid_val;
      end
      if (wr_hit && wr_i.wr_link) begin
        link_set_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_hit && wr_i.wr_key) begin
      key_q <= wr_i.key;
    end
    if (wr_hit && wr_i.wr_count) begin
      count_q <= wr_i.count;
    end
    if (wr_hit && wr_i.wr_link) begin
      link_q <= wr_i.link;
    end
  end

  assign probe_o = probe_q;

endmodule

[design/named_semaphore_table.sv]
// Named semaphore table: a probe walks a chain of NSEM cells, one cell a cycle.
// One item at a time: a new item is taken only after the previous probe has passed the cell chain and finished.
// A new item may be taken while the previous result waits in the output register.
// Reset: all entries free, free list in index order starting at entry 0.
`include "named_semaphore_table_assert.svh"

module named_semaphore_table (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [nst_pkg::OPCODE_W-1:0]       opcode_i,
  input  logic [nst_pkg::NAME_W-1:0]         sem_name_i,
  input  logic signed [nst_pkg::INIT_W-1:0]  initial_count_i,
  input  logic [nst_pkg::HANDLE_W-1:0]       handle_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [nst_pkg::STATUS_W-1:0]       status_o,
  output logic [nst_pkg::HANDLE_W-1:0]       result_handle_o,
  output logic signed [nst_pkg::INIT_W-1:0]  count_after_o,
  output logic                               wake_request_o
);
  import nst_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } state_e;

  state_e                     state_q;
  op_e                        op_q;
  logic [HANDLE_W-1:0]        handle_q;
  count_t                     init_q;
  link_t                      free_head_q;
  link_t                      head_d;
  probe_t                     fin_q;
  probe_t                     probe_in;
  probe_t                     chain [NSEM+1];
  logic [NSEM-1:0]            active_vec;
  wr_t                        wr;
  logic                       accept;
  logic                       fin_fire;
  logic                       out_valid_q;
  status_e                    status_q;
  status_e                    status_d;
  logic [HANDLE_W-1:0]        rhandle_q;
  logic [HANDLE_W-1:0]        rhandle_d;
  count_t                     cnt_out_q;
  count_t                     cnt_out_d;
  logic                       wake_q;
  logic                       wake_d;
  logic                       in_range;
  logic [HANDLE_W-1:0]        handle_m1;

  assign accept    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign fin_fire  = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
  assign handle_m1 = HANDLE_W'(handle_i - HANDLE_W'(1));

  always_comb begin
    probe_in        = '0;
    probe_in.active = accept;
    probe_in.is_get = (op_e'(opcode_i) == OP_GET);
    probe_in.name   = sem_name_i;
    probe_in.tgt    = probe_in.is_get ? free_head_q[IDX_W-1:0] : handle_m1[IDX_W-1:0];
  end

  assign chain[0] = probe_in;

  for (genvar i = 0; i < NSEM; i++) begin : g_cell
    nst_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(i)),
      .probe_i    (chain[i]),
      .probe_o    (chain[i+1]),
      .wr_i       (wr)
    );
    assign active_vec[i] = chain[i+1].active;
  end

  always_comb begin
    in_range  = (handle_q != '0) && (handle_q <= HANDLE_W'(NSEM));
    wr        = '0;
    wr.key    = '0;
    head_d    = free_head_q;
    status_d  = ST_OK;
    rhandle_d = handle_q;
    cnt_out_d = '0;
    wake_d    = 1'b0;
    wr.idx    = fin_q.tgt;
    unique case (op_q)
      OP_GET: begin
        if (fin_q.hit) begin
          wr.idx      = fin_q.hit_idx;
          wr.wr_count = 1'b1;
          wr.count    = init_q;
          rhandle_d   = HANDLE_W'(fin_q.hit_idx) + HANDLE_W'(1);
          cnt_out_d   = init_q;
        end else if (free_head_q == LINK_NONE) begin
          status_d  = ST_FULL;
          rhandle_d = '0;
        end else begin
          wr.idx       = free_head_q[IDX_W-1:0];
          wr.wr_valid  = 1'b1;
          wr.valid_val = 1'b1;
          wr.wr_key    = 1'b1;
          wr.key       = fin_q.name;
          wr.wr_count  = 1'b1;
          wr.count     = init_q;
          head_d       = fin_q.link;
          rhandle_d    = HANDLE_W'(free_head_q) + HANDLE_W'(1);
          cnt_out_d    = init_q;
        end
      end
      OP_SIGNAL: begin
        if (!in_range || !fin_q.hit) begin
          status_d = ST_BAD_HANDLE;
        end else begin
          wr.wr_count = 1'b1;
          wr.count    = (fin_q.cnt == CNT_MAX) ? fin_q.cnt : fin_q.cnt + count_t'(1);
          cnt_out_d   = wr.count;
          wake_d      = 1'b1;
        end
      end
      OP_WAIT: begin
        if (!in_range || !fin_q.hit) begin
          status_d = ST_BAD_HANDLE;
        end else if (fin_q.cnt > count_t'(0)) begin
          wr.wr_count = 1'b1;
          wr.count    = fin_q.cnt - count_t'(1);
          cnt_out_d   = wr.count;
        end else begin
          status_d  = ST_BLOCK;
          cnt_out_d = fin_q.cnt;
        end
      end
      OP_DELETE: begin
        if (!in_range || !fin_q.hit) begin
          status_d = ST_BAD_HANDLE;
        end else begin
          wr.wr_valid  = 1'b1;
          wr.valid_val = 1'b0;
          wr.wr_link   = 1'b1;
          wr.link      = free_head_q;
          head_d       = LINK_W'(fin_q.tgt);
        end
      end
      default: begin
        status_d = ST_BAD_HANDLE;
      end
    endcase
    wr.en = fin_fire && (wr.wr_valid || wr.wr_count);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_GET;
      handle_q    <= '0;
      init_q      <= '0;
      free_head_q <= '0;
      fin_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      rhandle_q   <= '0;
      cnt_out_q   <= '0;
      wake_q      <= 1'b0;
    end else begin
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q     <= op_e'(opcode_i);
            handle_q <= handle_i;
            init_q   <= clamp_init(initial_count_i);
            state_q  <= S_RUN;
          end
        end
        S_RUN: begin
          if (chain[NSEM].active) begin
            fin_q   <= chain[NSEM];
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_fire) begin
            free_head_q <= head_d;
            status_q    <= status_d;
            rhandle_q   <= rhandle_d;
            cnt_out_q   <= cnt_out_d;
            wake_q      <= wake_d;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign result_handle_o = rhandle_q;
  assign count_after_o   = INIT_W'(cnt_out_q);
  assign wake_request_o  = wake_q;

  `NST_ASSERT_IMPL(a_probe_in_run, chain[NSEM].active, state_q == S_RUN, "probe exits outside run")
  `NST_ASSERT_ALWAYS(a_one_probe, $onehot0(active_vec), "more than one probe in the chain")
  `NST_ASSERT_NEXT(a_fin_loads_out, fin_fire, out_valid_q, "finished item did not load output")
  `NST_ASSERT_ALWAYS(a_head_range, free_head_q <= LINK_NONE, "free list head out of range")

endmodule

[tb/tb_named_semaphore_table.sv]
// Self-checking testbench for named_semaphore_table: directed and random requests
// over valid/ready, checked against a behavioral model of the semaphore table.
// Depends on nst_pkg for sizes, count type, opcode and status enums.
module tb_named_semaphore_table;
  timeunit 1ns;
  timeprecision 1ps;

  import nst_pkg::*;

  localparam int NAME_POOL = 14;

  typedef struct {
    status_e               status;
    logic [HANDLE_W-1:0]   handle;
    count_t                count;
    logic                  wake;
  } sem_reply_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic [OPCODE_W-1:0]        opcode_i = '0;
  logic [NAME_W-1:0]          sem_name_i = '0;
  logic signed [INIT_W-1:0]   initial_count_i = '0;
  logic [HANDLE_W-1:0]        handle_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [STATUS_W-1:0]        status_o;
  logic [HANDLE_W-1:0]        result_handle_o;
  logic signed [INIT_W-1:0]   count_after_o;
  logic                       wake_request_o;

  logic                sem_valid [NSEM];
  logic [NAME_W-1:0]   sem_key   [NSEM];
  count_t              sem_count [NSEM];
  int                  free_next [NSEM];
  int                  free_head;
  logic [NAME_W-1:0]   name_pool [NAME_POOL];

  sem_reply_t expected_results[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent = 0;
  int checked = 0;
  int errors = 0;
  int status_seen [4] = '{0, 0, 0, 0};

  named_semaphore_table i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .sem_name_i      (sem_name_i),
    .initial_count_i (initial_count_i),
    .handle_i        (handle_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .result_handle_o (result_handle_o),
    .count_after_o   (count_after_o),
    .wake_request_o  (wake_request_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("FAIL named_semaphore_table");
    $finish;
  end

  function automatic sem_reply_t sem_apply(op_e op, logic [NAME_W-1:0] name,
                                           logic signed [INIT_W-1:0] init,
                                           logic [HANDLE_W-1:0] h);
    sem_reply_t r;
    count_t start;
    int slot;
    int idx;
    r.status = ST_OK;
    r.handle = h;
    r.count = '0;
    r.wake = 1'b0;
    slot = -1;
    if (int'(init) > int'(CNT_MAX)) begin
      start = CNT_MAX;
    end else if (int'(init) < int'(CNT_MIN)) begin
      start = CNT_MIN;
    end else begin
      start = count_t'(init);
    end
    if (op == OP_GET) begin
      for (int i = NSEM - 1; i >= 0; i--) begin
        if (sem_valid[i] && sem_key[i] == name) slot = i;
      end
      if (slot < 0 && free_head < NSEM) begin
        slot = free_head;
        free_head = free_next[slot];
        sem_valid[slot] = 1'b1;
        sem_key[slot] = name;
      end
      if (slot < 0) begin
        r.status = ST_FULL;
        r.handle = '0;
      end else begin
        sem_count[slot] = start;
        r.handle = HANDLE_W'(slot + 1);
        r.count = start;
      end
    end else if (h == 0 || h > NSEM || !sem_valid[h - 1]) begin
      r.status = ST_BAD_HANDLE;
    end else begin
      idx = int'(h) - 1;
      case (op)
        OP_SIGNAL: begin
          if (sem_count[idx] != CNT_MAX) sem_count[idx] = sem_count[idx] + 16'sd1;
          r.count = sem_count[idx];
          r.wake = 1'b1;
        end
        OP_WAIT: begin
          if (sem_count[idx] > 0) begin
            sem_count[idx] = sem_count[idx] - 16'sd1;
          end else begin
            r.status = ST_BLOCK;
          end
          r.count = sem_count[idx];
        end
        default: begin
          sem_valid[idx] = 1'b0;
          free_next[idx] = free_head;
          free_head = idx;
        end
      endcase
    end
    return r;
  endfunction

  function automatic logic [HANDLE_W-1:0] pick_handle();
    int live[$];
    for (int i = 0; i < NSEM; i++) begin
      if (sem_valid[i]) live.push_back(i + 1);
    end
    if (live.size() == 0 || $urandom_range(99) < 20) return HANDLE_W'($urandom_range(63));
    return HANDLE_W'(live[$urandom_range(live.size() - 1)]);
  endfunction

  function automatic logic [NAME_W-1:0] pick_name();
    if ($urandom_range(99) < 70) return name_pool[$urandom_range(NAME_POOL - 1)];
    return $urandom();
  endfunction

  function automatic logic signed [INIT_W-1:0] pick_init();
    int r;
    r = $urandom_range(99);
    if (r < 5) return CNT_MAX;
    if (r < 10) return CNT_MIN;
    if (r < 70) return INIT_W'(int'($urandom_range(6)) - 2);
    return INIT_W'($urandom());
  endfunction

  task automatic note_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR: %s", msg);
  endtask

  task automatic send_req(op_e op, logic [NAME_W-1:0] name,
                          logic signed [INIT_W-1:0] init, logic [HANDLE_W-1:0] h);
    sem_reply_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    sem_name_i <= name;
    initial_count_i <= init;
    handle_i <= h;
    do @(posedge clk_i); while (!in_ready_o);
    r = sem_apply(op, name, init, h);
    expected_results.push_back(r);
    status_seen[r.status]++;
    sent++;
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : result_check
    sem_reply_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        note_error($sformatf("unexpected result status=%0d handle=%0d count=%0d wake=%0d",
                             status_o, result_handle_o, count_after_o, wake_request_o));
      end else begin
        want = expected_results.pop_front();
        checked++;
        if (status_o !== want.status || result_handle_o !== want.handle ||
            count_after_o !== want.count || wake_request_o !== want.wake) begin
          note_error($sformatf({"result %0d: expected status=%0d handle=%0d count=%0d ",
                                "wake=%0d, got status=%0d handle=%0d count=%0d wake=%0d"},
                               checked, want.status, want.handle, want.count, want.wake,
                               status_o, result_handle_o, count_after_o, wake_request_o));
        end
      end
    end
  end

  task automatic test_directed();
    send_req(OP_GET, 32'h0000_0000, CNT_MAX, 6'd0);
    send_req(OP_SIGNAL, 32'h0, 16'sd0, 6'd1);
    send_req(OP_WAIT, 32'h0, 16'sd0, 6'd1);
    send_req(OP_GET, 32'hFFFF_FFFF, CNT_MIN, 6'd63);
    send_req(OP_WAIT, 32'h0, 16'sd0, 6'd2);
    send_req(OP_SIGNAL, 32'h0, 16'sd0, 6'd2);
    send_req(OP_GET, 32'h0000_0000, 16'sd0, 6'd0);
    send_req(OP_WAIT, 32'h0, 16'sd0, 6'd1);
    send_req(OP_SIGNAL, 32'h0, 16'sd0, 6'd1);
    send_req(OP_WAIT, 32'h0, 16'sd0, 6'd1);
    send_req(OP_SIGNAL, 32'h0, 16'sd0, 6'd0);
    send_req(OP_WAIT, 32'h0, 16'sd0, 6'd33);
    send_req(OP_DELETE, 32'h0, 16'sd0, 6'd63);
    send_req(OP_SIGNAL, 32'h0, 16'sd0, 6'd32);
    send_req(OP_DELETE, 32'h0, 16'sd0, 6'd1);
    send_req(OP_WAIT, 32'h0, 16'sd0, 6'd1);
    send_req(OP_DELETE, 32'h0, 16'sd0, 6'd1);
    send_req(OP_GET, 32'h8000_0001, -16'sd1, 6'd0);
    send_req(OP_DELETE, 32'h0, 16'sd0, 6'd2);
    send_req(OP_GET, 32'h7FFF_FFFE, 16'sd1, 6'd0);
    send_req(OP_GET, 32'h0000_0000, 16'sd5, 6'd0);
    send_req(OP_WAIT, 32'h0, 16'sd0, 6'd3);
  endtask

  task automatic test_table_full();
    int full_base;
    int tries;
    full_base = status_seen[ST_FULL];
    tries = 0;
    while (status_seen[ST_FULL] == full_base && tries < 2 * NSEM) begin
      send_req(OP_GET, $urandom(), pick_init(), HANDLE_W'($urandom_range(63)));
      tries++;
    end
    repeat (4) send_req(OP_GET, pick_name(), pick_init(), HANDLE_W'($urandom_range(63)));
  endtask

  task automatic test_random_traffic(int n, int get_pct, int del_pct);
    int r;
    op_e op;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < get_pct) begin
        op = OP_GET;
      end else if (r < get_pct + del_pct) begin
        op = OP_DELETE;
      end else if ($urandom_range(1) == 0) begin
        op = OP_SIGNAL;
      end else begin
        op = OP_WAIT;
      end
      send_req(op, pick_name(), pick_init(), pick_handle());
    end
  endtask

  initial begin
    for (int i = 0; i < NSEM; i++) begin
      sem_valid[i] = 1'b0;
      sem_key[i] = '0;
      sem_count[i] = '0;
      free_next[i] = i + 1;
    end
    free_head = 0;
    name_pool[0] = 32'h0000_0000;
    name_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < NAME_POOL; i++) name_pool[i] = $urandom();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 34;
    recv_idle_pct = 53;
    test_directed();
    test_table_full();
    test_random_traffic(140, 40, 15);
    wait_for_results();

    send_idle_pct = 53;
    recv_idle_pct = 34;
    test_random_traffic(150, 30, 30);
    wait_for_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(150, 35, 20);
    wait_for_results();
    repeat (2 * NSEM) @(posedge clk_i);

    $display("Sent %0d requests: directed cases, a full table, and mixed traffic", sent);
    $display("Outcomes: %0d ok, %0d full, %0d bad handle, %0d would block; %0d checked",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_BAD_HANDLE],
             status_seen[ST_BLOCK], checked);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS named_semaphore_table");
    end else begin
      $display("FAIL named_semaphore_table");
    end
    $finish;
  end

endmodule
